/* sv/qxmix_pkg.sv */
`default_nettype none
package qxmix_pkg;

  localparam int PWM_BITS   = 11;
  localparam int ONE_Q14    = 16384;
  localparam int CODE_W     = 18;
  localparam int PWM_FLOOR  = 10;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_WRITE_INTERVAL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_THRUST     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FULL_START     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BAND_GAIN      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE     = 3'd4;

  typedef struct packed {
    logic [15:0]         min_write_interval_us;
    logic [14:0]         min_thrust_level;
    logic [14:0]         full_control_start;
    logic [14:0]         band_gain;
    logic [PWM_BITS-1:0] full_scale_pwm;
  } qx_cfg_t;

  typedef struct packed {
    logic signed [15:0] roll_command;
    logic signed [15:0] pitch_command;
    logic signed [15:0] yaw_command;
    logic signed [15:0] thrust_command;
    logic               simulation_mode;
    logic [31:0]        now_us;
  } qx_in_t;

  typedef struct packed {
    logic [PWM_BITS-1:0] pwm_front;
    logic [PWM_BITS-1:0] pwm_right;
    logic [PWM_BITS-1:0] pwm_back;
    logic [PWM_BITS-1:0] pwm_left;
    logic                write_accepted;
    logic                drive_enabled;
  } qx_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P,
    ST_BAND,
    ST_MG,
    ST_MIX,
    ST_PWM0,
    ST_PWM1,
    ST_PWM2,
    ST_PWM3,
    ST_FIN,
    ST_DONE
  } qx_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_BAND,
    MUL_MG,
    MUL_PWM
  } mul_sel_t;

  typedef struct packed {
    logic       capture;
    mul_sel_t   mul_sel;
    logic [1:0] mul_idx;
    logic       load_p;
    logic       load_band;
    logic       load_mg;
    logic       load_mix;
    logic       store_pwm;
    logic [1:0] store_idx;
    logic       load_out;
  } qx_cmd_t;

  typedef struct packed {
    logic out_free;
  } qx_stat_t;

endpackage
`default_nettype wire

/* sv/qxmix_if.sv */
`default_nettype none
interface qxmix_cmd_if;
  import qxmix_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_command;
  logic signed [15:0] pitch_command;
  logic signed [15:0] yaw_command;
  logic signed [15:0] thrust_command;
  logic               simulation_mode;
  logic [31:0]        now_us;

  modport source(output valid, roll_command, pitch_command, yaw_command, thrust_command,
                 simulation_mode, now_us, input ready);
  modport sink(input valid, roll_command, pitch_command, yaw_command, thrust_command,
               simulation_mode, now_us, output ready);
endinterface

interface qxmix_pwm_if;
  import qxmix_pkg::*;
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] pwm_front;
  logic [PWM_BITS-1:0] pwm_right;
  logic [PWM_BITS-1:0] pwm_back;
  logic [PWM_BITS-1:0] pwm_left;
  logic                write_accepted;
  logic                drive_enabled;

  modport source(output valid, pwm_front, pwm_right, pwm_back, pwm_left, write_accepted,
                 drive_enabled, input ready);
  modport sink(input valid, pwm_front, pwm_right, pwm_back, pwm_left, write_accepted,
               drive_enabled, output ready);
endinterface

interface qxmix_cfg_if;
  import qxmix_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

/* sv/qxmix_cfg_regs.sv */
`default_nettype none
module qxmix_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  qxmix_cfg_if.sink         cfg,
  output qxmix_pkg::qx_cfg_t regs
);
  import qxmix_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_write_interval_us <= 16'd4900;
      regs.min_thrust_level      <= 15'd492;
      regs.full_control_start    <= 15'd4096;
      regs.band_gain             <= 15'd12288;
      regs.full_scale_pwm        <= PWM_BITS'(2040);
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_WRITE_INTERVAL: regs.min_write_interval_us <= cfg.data;
        REG_MIN_THRUST:     regs.min_thrust_level      <= cfg.data[14:0];
        REG_FULL_START:     regs.full_control_start    <= cfg.data[14:0];
        REG_BAND_GAIN:      regs.band_gain             <= cfg.data[14:0];
        REG_FULL_SCALE:     regs.full_scale_pwm        <= cfg.data[PWM_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/qxmix_ctrl.sv */
`default_nettype none
module qxmix_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  qxmix_pkg::qx_stat_t stat,
  output logic                in_ready,
  output qxmix_pkg::qx_cmd_t  cmd
);
  import qxmix_pkg::*;

  qx_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_P;
      ST_P:    state_next = ST_BAND;
      ST_BAND: state_next = ST_MG;
      ST_MG:   state_next = ST_MIX;
      ST_MIX:  state_next = ST_PWM0;
      ST_PWM0: state_next = ST_PWM1;
      ST_PWM1: state_next = ST_PWM2;
      ST_PWM2: state_next = ST_PWM3;
      ST_PWM3: state_next = ST_FIN;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MUL_NONE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_P: cmd.mul_sel = MUL_P;
      ST_BAND: begin
        cmd.mul_sel = MUL_BAND;
        cmd.load_p  = 1'b1;
      end
      ST_MG: begin
        cmd.mul_sel   = MUL_MG;
        cmd.load_band = 1'b1;
      end
      ST_MIX: begin
        cmd.load_mg  = 1'b1;
        cmd.load_mix = 1'b1;
      end
      ST_PWM0: begin
        cmd.mul_sel = MUL_PWM;
        cmd.mul_idx = 2'd0;
      end
      ST_PWM1: begin
        cmd.mul_sel   = MUL_PWM;
        cmd.mul_idx   = 2'd1;
        cmd.store_pwm = 1'b1;
        cmd.store_idx = 2'd0;
      end
      ST_PWM2: begin
        cmd.mul_sel   = MUL_PWM;
        cmd.mul_idx   = 2'd2;
        cmd.store_pwm = 1'b1;
        cmd.store_idx = 2'd1;
      end
      ST_PWM3: begin
        cmd.mul_sel   = MUL_PWM;
        cmd.mul_idx   = 2'd3;
        cmd.store_pwm = 1'b1;
        cmd.store_idx = 2'd2;
      end
      ST_FIN: begin
        cmd.store_pwm = 1'b1;
        cmd.store_idx = 2'd3;
      end
      ST_DONE: cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/qxmix_dp.sv */
`default_nettype none
module qxmix_dp (
  input  logic                clk,
  input  logic                rst,
  input  qxmix_pkg::qx_cmd_t  cmd,
  input  qxmix_pkg::qx_cfg_t  cfg,
  input  qxmix_pkg::qx_in_t   in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output qxmix_pkg::qx_out_t  out_item,
  output qxmix_pkg::qx_stat_t stat
);
  import qxmix_pkg::*;

  qx_in_t                   in_q;
  logic [31:0]              last_write_time;
  logic signed [46:0]       prod_q;
  logic [15:0]              p_q;
  logic [15:0]              band_q;
  logic [24:0]              mg_q;
  logic signed [19:0]       v2 [4];
  logic [PWM_BITS-1:0]      pwm_q [4];

  logic [14:0]              mt;
  logic                     below;
  logic [14:0]              t;
  logic                     t_lt_start;
  logic [14:0]              band_op;
  logic [24:0]              span;
  logic signed [19:0]       mul_a;
  logic signed [26:0]       mul_b;
  logic signed [46:0]       prod;
  logic [14:0]              prod_band;
  logic signed [17:0]       p_limit;
  logic [15:0]              band_next;
  logic signed [19:0]       t2, band2, lo, hi;
  logic signed [19:0]       roll2, pitch2, yaw2, yaw1;
  logic signed [19:0]       m_full [4];
  logic signed [19:0]       m_half [4];
  logic signed [19:0]       m_sel [4];
  logic                     in_band;
  logic signed [46:0]       num;
  logic [CODE_W-1:0]        code_raw, code_floor;
  logic [PWM_BITS-1:0]      code;
  logic                     out_free;
  logic [31:0]              elapsed;
  logic                     accept_write;

  always_ff @(posedge clk) begin
    if (cmd.capture) in_q <= in_item;
  end

  // thrust floor and saturation
  assign mt = (cfg.min_thrust_level > 15'(ONE_Q14)) ? 15'(ONE_Q14) : cfg.min_thrust_level;
  assign below = in_q.thrust_command <= $signed({1'b0, mt});
  always_comb begin
    if (below) begin
      t = mt;
    end else if (in_q.thrust_command > 16'sd16384) begin
      t = 15'(ONE_Q14);
    end else begin
      t = in_q.thrust_command[14:0];
    end
  end
  assign t_lt_start = t < cfg.full_control_start;
  assign band_op    = t_lt_start ? (t - mt) : (15'(ONE_Q14) - t);
  assign span       = {cfg.full_scale_pwm, 14'b0} - mg_q;

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({5'b0, cfg.band_gain});
        mul_b = $signed({12'b0, cfg.full_control_start});
      end
      MUL_BAND: begin
        mul_a = $signed({5'b0, cfg.band_gain});
        mul_b = $signed({12'b0, band_op});
      end
      MUL_MG: begin
        mul_a = $signed({5'b0, mt});
        mul_b = $signed({(27-PWM_BITS)'(0), cfg.full_scale_pwm});
      end
      MUL_PWM: begin
        mul_a = v2[cmd.mul_idx];
        mul_b = $signed({2'b0, span});
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_q <= prod;
  end

  // band: zero below the floor, ramp up, flat plateau, ramp down towards 1.0
  assign prod_band = prod_q[28:14];
  assign p_limit   = 18'sd16384 - $signed({2'b0, p_q});
  always_comb begin
    if (below) begin
      band_next = '0;
    end else if (t_lt_start) begin
      band_next = {1'b0, prod_band};
    end else if ($signed({3'b0, t}) < p_limit) begin
      band_next = p_q;
    end else begin
      band_next = {1'b0, prod_band};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_p)    p_q    <= prod_q[29:14];
    if (cmd.load_band) band_q <= band_next;
    if (cmd.load_mg)   mg_q   <= prod_q[24:0];
  end

  // mix in Q.15 so halving yaw stays exact
  assign t2     = $signed({4'b0, t, 1'b0});
  assign band2  = $signed({3'b0, band_q, 1'b0});
  assign lo     = t2 - band2;
  assign hi     = t2 + band2;
  assign roll2  = $signed({{3{in_q.roll_command[15]}}, in_q.roll_command, 1'b0});
  assign pitch2 = $signed({{3{in_q.pitch_command[15]}}, in_q.pitch_command, 1'b0});
  assign yaw2   = $signed({{3{in_q.yaw_command[15]}}, in_q.yaw_command, 1'b0});
  assign yaw1   = $signed({{4{in_q.yaw_command[15]}}, in_q.yaw_command});

  always_comb begin
    m_full[0] = t2 + pitch2 - yaw2;
    m_full[1] = t2 - roll2 + yaw2;
    m_full[2] = t2 - pitch2 - yaw2;
    m_full[3] = t2 + roll2 + yaw2;
    m_half[0] = t2 + pitch2 - yaw1;
    m_half[1] = t2 - roll2 + yaw1;
    m_half[2] = t2 - pitch2 - yaw1;
    m_half[3] = t2 + roll2 + yaw1;
    in_band = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (!(m_full[i] < hi && m_full[i] > lo)) in_band = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      m_sel[i] = in_band ? m_full[i] : m_half[i];
      if (m_sel[i] < lo) m_sel[i] = lo;
      if (m_sel[i] > hi) m_sel[i] = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mix) begin
      for (int i = 0; i < 4; i++) v2[i] <= m_sel[i];
    end
  end

  // PWM code: floor((v*span + mg*2^15) / 2^29), then the floor code, then full scale
  assign num        = prod_q + $signed({7'b0, mg_q, 15'b0});
  assign code_raw   = (num <= 47'sd0) ? '0 : num[46:29];
  assign code_floor = (code_raw == '0) ? CODE_W'(PWM_FLOOR) : code_raw;
  assign code       = (code_floor > CODE_W'(cfg.full_scale_pwm)) ? cfg.full_scale_pwm
                                                                 : code_floor[PWM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store_pwm) pwm_q[cmd.store_idx] <= code;
  end

  // write gating on the wrapping microsecond timer
  assign elapsed      = in_q.now_us - last_write_time;
  assign accept_write = elapsed > 32'(cfg.min_write_interval_us);
  assign out_free     = !out_valid || out_ready;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      last_write_time <= '0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
      if (accept_write) last_write_time <= in_q.now_us;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.pwm_front      <= pwm_q[0];
      out_item.pwm_right      <= pwm_q[1];
      out_item.pwm_back       <= pwm_q[2];
      out_item.pwm_left       <= pwm_q[3];
      out_item.write_accepted <= accept_write;
      out_item.drive_enabled  <= accept_write && !in_q.simulation_mode;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over an untaken beat");

  a_valid_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result beat not presented after load");

  a_drive_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.drive_enabled |-> out_item.write_accepted)
    else $error("drive enabled without an accepted write");

  a_timestamp_update: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && accept_write |=> last_write_time == $past(in_q.now_us))
    else $error("last write time not updated on accepted write");

endmodule
`default_nettype wire

/* sv/quad_x_motor_mixer_rate_gated_unit.sv */
// A command steps through states P to DONE; its result is loaded once the output is free.
// A new command is taken only after that load; one shared 20x27 multiplier is stepped
// through plateau, band, minimum gas and the four motor codes in turn.
// A finished result waits in the output register while the next command is taken.
// Reset (synchronous, active high): registers return to defaults, last write time
// is cleared, the controller idles and no result is pending.
`default_nettype none
module quad_x_motor_mixer_rate_gated_unit (
  input  logic        clk,
  input  logic        rst,
  qxmix_cmd_if.sink   cmd,
  qxmix_pwm_if.source pwm,
  qxmix_cfg_if.sink   cfg
);
  import qxmix_pkg::*;

  qx_cfg_t  cfg_regs;
  qx_in_t   in_item;
  qx_out_t  out_item;
  qx_cmd_t  dp_cmd;
  qx_stat_t dp_stat;
  logic     in_ready;
  logic     out_valid;

  qxmix_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  assign in_item.roll_command    = cmd.roll_command;
  assign in_item.pitch_command   = cmd.pitch_command;
  assign in_item.yaw_command     = cmd.yaw_command;
  assign in_item.thrust_command  = cmd.thrust_command;
  assign in_item.simulation_mode = cmd.simulation_mode;
  assign in_item.now_us          = cmd.now_us;

  qxmix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .stat     (dp_stat),
    .in_ready (in_ready),
    .cmd      (dp_cmd)
  );

  qxmix_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .cfg       (cfg_regs),
    .in_item   (in_item),
    .out_ready (pwm.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (dp_stat)
  );

  assign cmd.ready          = in_ready;
  assign pwm.valid          = out_valid;
  assign pwm.pwm_front      = out_item.pwm_front;
  assign pwm.pwm_right      = out_item.pwm_right;
  assign pwm.pwm_back       = out_item.pwm_back;
  assign pwm.pwm_left       = out_item.pwm_left;
  assign pwm.write_accepted = out_item.write_accepted;
  assign pwm.drive_enabled  = out_item.drive_enabled;

endmodule
`default_nettype wire

/* tb/sv/qxmix_pwm_checker.sv */
module qxmix_pwm_checker (
  input  logic  clk,
  input  logic  rst,
  qxmix_cmd_if  cmd,
  qxmix_pwm_if  pwm,
  qxmix_cfg_if  cfg,
  output int    fails,
  output int    pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  import qxmix_pkg::*;

  localparam qx_cfg_t REG_DEFAULTS = '{16'd4900, 15'd492, 15'd4096, 15'd12288, 11'd2040};

  qx_cfg_t     regs_mirror;
  logic [31:0] last_write_us;
  qx_out_t     motor_codes_due[$];

  initial begin
    fails = 0;
    pending_beats = 0;
  end

  function automatic qx_out_t mix_motor_codes(input qx_in_t c, input qx_cfg_t k,
                                              input logic [31:0] last_us);
    longint roll, pitch, yaw, thr;
    longint floor_thr, knee, gain, fs, p, t, band, lo, hi, mg, span, num, code;
    longint mix[4];
    logic [PWM_BITS-1:0] code_of[4];
    logic [31:0] elapsed;
    bit in_band;
    qx_out_t r;
    roll  = longint'($signed(c.roll_command));
    pitch = longint'($signed(c.pitch_command));
    yaw   = longint'($signed(c.yaw_command));
    thr   = longint'($signed(c.thrust_command));
    knee  = longint'(k.full_control_start);
    gain  = longint'(k.band_gain);
    fs    = longint'(k.full_scale_pwm);
    floor_thr = longint'(k.min_thrust_level);
    if (floor_thr > ONE_Q14) floor_thr = ONE_Q14;
    p = (gain * knee) >> 14;

    if (thr <= floor_thr) begin
      t = floor_thr;
      band = 0;
    end else begin
      t = (thr > ONE_Q14) ? ONE_Q14 : thr;
      if (t < knee) band = (gain * (t - floor_thr)) >> 14;
      else if (t < ONE_Q14 - p) band = p;
      else band = (gain * (ONE_Q14 - t)) >> 14;
    end

    // everything below in Q.15 so that halving yaw stays exact
    lo = 2 * (t - band);
    hi = 2 * (t + band);
    mix[0] = 2 * t + 2 * pitch - 2 * yaw;
    mix[1] = 2 * t - 2 * roll + 2 * yaw;
    mix[2] = 2 * t - 2 * pitch - 2 * yaw;
    mix[3] = 2 * t + 2 * roll + 2 * yaw;
    in_band = 1'b1;
    foreach (mix[i]) if (!(mix[i] < hi && mix[i] > lo)) in_band = 1'b0;
    if (!in_band) begin
      mix[0] = 2 * t + 2 * pitch - yaw;
      mix[1] = 2 * t - 2 * roll + yaw;
      mix[2] = 2 * t - 2 * pitch - yaw;
      mix[3] = 2 * t + 2 * roll + yaw;
    end

    mg   = floor_thr * fs;
    span = fs * ONE_Q14 - mg;
    foreach (mix[i]) begin
      if (mix[i] < lo) mix[i] = lo;
      if (mix[i] > hi) mix[i] = hi;
      // Q.15 value times Q14-scaled span: drop 29 fraction bits
      num  = mix[i] * span + mg * 32768;
      code = (num <= 0) ? 0 : (num >> 29);
      if (code == 0) code = PWM_FLOOR;
      if (code > fs) code = fs;
      code_of[i] = code[PWM_BITS-1:0];
    end

    r.pwm_front = code_of[0];
    r.pwm_right = code_of[1];
    r.pwm_back  = code_of[2];
    r.pwm_left  = code_of[3];
    elapsed = c.now_us - last_us;
    r.write_accepted = (elapsed > 32'(k.min_write_interval_us));
    r.drive_enabled  = r.write_accepted && !c.simulation_mode;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [PWM_BITS-1:0] want,
                             input logic [PWM_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    qx_in_t  seen;
    qx_out_t want;
    if (rst) begin
      regs_mirror = REG_DEFAULTS;
      last_write_us = '0;
      motor_codes_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_WRITE_INTERVAL: regs_mirror.min_write_interval_us = cfg.data;
          REG_MIN_THRUST:     regs_mirror.min_thrust_level = cfg.data[14:0];
          REG_FULL_START:     regs_mirror.full_control_start = cfg.data[14:0];
          REG_BAND_GAIN:      regs_mirror.band_gain = cfg.data[14:0];
          REG_FULL_SCALE:     regs_mirror.full_scale_pwm = cfg.data[PWM_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.valid && cmd.ready) begin
        seen.roll_command    = cmd.roll_command;
        seen.pitch_command   = cmd.pitch_command;
        seen.yaw_command     = cmd.yaw_command;
        seen.thrust_command  = cmd.thrust_command;
        seen.simulation_mode = cmd.simulation_mode;
        seen.now_us          = cmd.now_us;
        want = mix_motor_codes(seen, regs_mirror, last_write_us);
        if (want.write_accepted) last_write_us = seen.now_us;
        motor_codes_due.push_back(want);
      end

      if (pwm.valid && pwm.ready) begin
        if (motor_codes_due.size() == 0) begin
          $display("%0t: result beat expected none actual %0d %0d %0d %0d %0b %0b", $time,
                   pwm.pwm_front, pwm.pwm_right, pwm.pwm_back, pwm.pwm_left,
                   pwm.write_accepted, pwm.drive_enabled);
          fails++;
        end else begin
          want = motor_codes_due.pop_front();
          check_field("pwm_front", want.pwm_front, pwm.pwm_front);
          check_field("pwm_right", want.pwm_right, pwm.pwm_right);
          check_field("pwm_back", want.pwm_back, pwm.pwm_back);
          check_field("pwm_left", want.pwm_left, pwm.pwm_left);
          check_field("write_accepted", PWM_BITS'(want.write_accepted),
                      PWM_BITS'(pwm.write_accepted));
          check_field("drive_enabled", PWM_BITS'(want.drive_enabled),
                      PWM_BITS'(pwm.drive_enabled));
        end
      end
    end
    pending_beats = motor_codes_due.size();
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qxmix_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 14;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_SETTINGS  = 6;

  typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst;
  int   fails;
  int   pending_beats;
  int   idle_pct;
  int   stall_pct;
  bit   hold_req;
  bit   hold_over;

  qx_cfg_t     cur;
  logic [31:0] now_clock;

  qxmix_cmd_if cmd();
  qxmix_pwm_if pwm();
  qxmix_cfg_if cfg();

  quad_x_motor_mixer_rate_gated_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .pwm(pwm),
    .cfg(cfg)
  );

  qxmix_pwm_checker i_checker (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .pwm(pwm),
    .cfg(cfg),
    .fails(fails),
    .pending_beats(pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_ready
    int held;
    held = 0;
    pwm.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_over) begin
        pwm.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_over = 1'b1;
      end else begin
        pwm.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic qx_in_t mk_cmd(input int roll, input int pitch, input int yaw,
                                    input int thr, input bit sim, input logic [31:0] now);
    qx_in_t c;
    c.roll_command    = 16'(roll);
    c.pitch_command   = 16'(pitch);
    c.yaw_command     = 16'(yaw);
    c.thrust_command  = 16'(thr);
    c.simulation_mode = sim;
    c.now_us          = now;
    return c;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(4))
      0: return 16'($urandom_range(0, 400) - 200);
      1: return 16'($urandom_range(0, 4000) - 2000);
      2: return 16'($urandom);
      3: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h4000;
          3: return 16'hC000;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(0, 1000) - 500);
    endcase
  endfunction

  function automatic qx_in_t next_flight_cmd();
    qx_in_t c;
    int floor_thr, knee, p, gap_us;
    logic [31:0] step;
    floor_thr = int'(cur.min_thrust_level);
    if (floor_thr > ONE_Q14) floor_thr = ONE_Q14;
    knee = int'(cur.full_control_start);
    p = (int'(cur.band_gain) * knee) >> 14;
    c.roll_command  = pick_axis();
    c.pitch_command = pick_axis();
    c.yaw_command   = pick_axis();
    // thrust near the band corners in half of the picks
    case ($urandom_range(5))
      0: c.thrust_command = 16'($urandom_range(0, ONE_Q14));
      1: c.thrust_command = 16'($urandom);
      2: c.thrust_command = 16'(floor_thr + $urandom_range(0, 2) - 1);
      3: c.thrust_command = 16'(knee + $urandom_range(0, 2) - 1);
      4: c.thrust_command = 16'(ONE_Q14 - p + $urandom_range(0, 2) - 1);
      default: c.thrust_command = 16'($urandom_range(6000, 12000));
    endcase
    c.simulation_mode = 1'($urandom_range(1));
    gap_us = int'(cur.min_write_interval_us);
    case ($urandom_range(7))
      0: step = '0;
      1: step = gap_us;
      2: step = gap_us + 1;
      3: step = $urandom;
      default: step = $urandom_range(0, 2 * gap_us + 2);
    endcase
    now_clock = now_clock + step;
    c.now_us = now_clock;
    return c;
  endfunction

  function automatic qx_cfg_t random_setting();
    qx_cfg_t s;
    s.min_write_interval_us = 16'($urandom_range(0, 65535));
    if ($urandom_range(3) == 0) s.min_thrust_level = 15'($urandom_range(ONE_Q14 + 1, 32767));
    else s.min_thrust_level = 15'($urandom_range(0, ONE_Q14));
    s.full_control_start = 15'($urandom_range(0, ONE_Q14));
    s.band_gain          = 15'($urandom_range(0, ONE_Q14));
    s.full_scale_pwm     = PWM_BITS'($urandom_range(1, 2047));
    return s;
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    idle_pct  = (mode == IDLE_SOURCE) ? 80 : (mode == IDLE_BOTH) ? 26 : 0;
    stall_pct = (mode == IDLE_SINK) ? 80 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  // entered and left at a falling edge; valid stays high into the next beat
  task automatic send_cmd(input qx_in_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid           <= 1'b1;
    cmd.roll_command    <= c.roll_command;
    cmd.pitch_command   <= c.pitch_command;
    cmd.yaw_command     <= c.yaw_command;
    cmd.thrust_command  <= c.thrust_command;
    cmd.simulation_mode <= c.simulation_mode;
    cmd.now_us          <= c.now_us;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    cmd.valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // unused upper data bits carry junk; the registers must drop them
  task automatic apply_setting(input qx_cfg_t s);
    logic [CFG_DATA_W-1:0] junk;
    logic [REG_IDX_W-1:0]  stray;
    junk  = CFG_DATA_W'($urandom);
    stray = REG_IDX_W'(REG_FULL_SCALE + $urandom_range(1, 3));
    write_reg(REG_WRITE_INTERVAL, s.min_write_interval_us);
    write_reg(REG_MIN_THRUST, {junk[15], s.min_thrust_level});
    write_reg(REG_FULL_START, {junk[14], s.full_control_start});
    write_reg(REG_BAND_GAIN, {junk[13], s.band_gain});
    write_reg(REG_FULL_SCALE, {junk[15:11], s.full_scale_pwm});
    write_reg(stray, ~junk);
    cur = s;
  endtask

  initial begin : stimulus
    qx_in_t  directed_cmds[$];
    qx_cfg_t settings[NUM_SETTINGS];
    rst = 1'b1;
    hold_req = 1'b0;
    hold_over = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    now_clock = '0;
    cmd.valid = 1'b0;
    cmd.roll_command = '0;
    cmd.pitch_command = '0;
    cmd.yaw_command = '0;
    cmd.thrust_command = '0;
    cmd.simulation_mode = 1'b0;
    cmd.now_us = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = '0;
    cfg.data = '0;
    cur = '{16'd4900, 15'd492, 15'd4096, 15'd12288, 11'd2040};

    settings[0] = '{16'd0, 15'd0, 15'd0, 15'd0, 11'd1};
    settings[1] = '{16'hFFFF, 15'd16384, 15'd16384, 15'd16384, 11'd2047};
    settings[2] = '{16'd4900, 15'h7FFF, 15'd4096, 15'd12288, 11'd2040};
    settings[3] = random_setting();
    settings[4] = cur;
    settings[5] = random_setting();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // defaults: interval edge, thrust corners, saturation, yaw halving, timer wrap
    directed_cmds.push_back(mk_cmd(0, 0, 0, 0, 1'b0, 32'd4900));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 492, 1'b1, 32'd4901));
    directed_cmds.push_back(mk_cmd(0, 0, 0, -32768, 1'b0, 32'd4902));
    directed_cmds.push_back(mk_cmd(100, -100, 50, 8000, 1'b0, 32'd9802));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 16384, 1'b0, 32'd9803));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 32767, 1'b1, 32'd20000));
    directed_cmds.push_back(mk_cmd(32767, -32768, 32767, 8000, 1'b0, 32'd20001));
    directed_cmds.push_back(mk_cmd(-32768, 32767, -32768, 8000, 1'b1, 32'd30000));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 4095, 1'b0, 32'd34901));
    directed_cmds.push_back(mk_cmd(200, 0, 0, 4096, 1'b0, 32'd40000));
    directed_cmds.push_back(mk_cmd(0, 300, 0, 13311, 1'b0, 32'd45000));
    directed_cmds.push_back(mk_cmd(0, 0, -300, 13312, 1'b0, 32'd50000));
    directed_cmds.push_back(mk_cmd(500, 500, 3000, 8000, 1'b0, 32'd55000));
    directed_cmds.push_back(mk_cmd(1500, -1500, 0, 12000, 1'b1, 32'd60000));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 493, 1'b0, 32'd65000));
    directed_cmds.push_back(mk_cmd(-1, -1, -1, -1, 1'b1, 32'hFFFF_FFF0));
    directed_cmds.push_back(mk_cmd(0, 0, 0, 10000, 1'b0, 32'h0000_1400));
    directed_cmds.push_back(mk_cmd(16384, 16384, 16384, 16384, 1'b0, 32'h0000_1401));
    directed_cmds.push_back(mk_cmd(-16384, -16384, -16384, 16383, 1'b0, 32'h8000_0000));
    directed_cmds.push_back(mk_cmd(-2, 2, 1, 8192, 1'b1, 32'h7FFF_FFFF));
    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);
    wait_for_results();

    now_clock = 32'h8000_0000;
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      apply_setting(settings[ph]);
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 0) begin
        // output side holds off while commands keep coming: input must back up
        hold_req = 1'b1;
        while (!hold_over) send_cmd(next_flight_cmd());
      end
      repeat (PHASE_ITEMS) send_cmd(next_flight_cmd());
      wait_for_results();
    end

    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
